### src/fcw_pkg.sv
// Shared types, constants and the tanh table for the four-curve waveshaper.
// Depends on nothing; every module of the block imports it.
package fcw_pkg;

  // Table size; must be a power of two between 32 and 4096.
  localparam int TANH_TABLE_ENTRIES = 256;
  localparam int TANH_IDX_W         = $clog2(TANH_TABLE_ENTRIES);
  localparam int TANH_W             = 21;

  localparam int SAMPLE_W    = 24;
  localparam int GAIN_W      = 16;
  localparam int PROD_W      = SAMPLE_W + GAIN_W;
  localparam int ROUND_SHIFT = 12;
  localparam int ROUND_HALF  = 2048;
  localparam int MAG_W       = 27;
  localparam int FRAC_W      = 20;
  localparam int ONE_Q20     = 1 << FRAC_W;
  localparam int SPAN_SHIFT  = 23;
  localparam int VAL_W       = 21;
  localparam int TWO_THIRDS  = 699051;
  localparam int OUT_MAX     = 8388607;
  localparam int OUT_MIN     = -8388608;

  // Tube square term: round(d^2 / (10 * 2^20)) = floor(floor((d^2 + 5*2^20) / 2^21) / 5)
  localparam int SQ_W        = 2 * MAG_W;
  localparam int TUBE_BIAS   = 5 << FRAC_W;
  localparam int YB_SHIFT    = FRAC_W + 1;
  localparam int YB_FULL_W   = SQ_W + 1 - YB_SHIFT;
  localparam int YB_W        = 27;
  localparam int YB_LIMIT    = 5 << 24;
  localparam int RECIP5_W    = 30;
  localparam logic [RECIP5_W-1:0] RECIP5 = 30'd858993460;
  localparam int RECIP5_SHIFT = 32;
  localparam int TUBE_B_W    = 24;

  // Soft clip cube term: round(d^3 / (3 * 2^40)) = floor(floor((d^3 + 3*2^39) / 2^40) / 3)
  localparam int SOFT_SQ_W   = 2 * FRAC_W;
  localparam int CUBE_W      = 3 * FRAC_W;
  localparam int Y3_SHIFT    = 2 * FRAC_W;
  localparam int Y3_W        = CUBE_W + 1 - Y3_SHIFT;
  localparam int RECIP3_W    = 22;
  localparam logic [RECIP3_W-1:0] RECIP3 = 22'd2796203;
  localparam int RECIP3_SHIFT = 23;

  // Tube divider: round(d * 2^20 / (2^20 + d)), one quotient bit per stage
  localparam int DIV_Q_BITS = 21;
  localparam int DIV_NUM_W  = 48;
  localparam int DEN_W      = 28;
  localparam int DIV_LAT    = DIV_Q_BITS + 1;
  localparam int CURVE_LAT  = 5;
  localparam int SIDE_DELAY = DIV_LAT - CURVE_LAT;

  localparam int RES_W = 26;

  typedef enum logic [1:0] {
    CURVE_TAPE = 2'd0,
    CURVE_TUBE = 2'd1,
    CURVE_SOFT = 2'd2,
    CURVE_HARD = 2'd3
  } curve_t;

  typedef struct packed {
    logic             valid;
    logic             neg;
    curve_t           curve;
    logic [MAG_W-1:0] mag;
  } fcw_mag_t;

  typedef struct packed {
    logic                valid;
    logic                neg;
    curve_t              curve;
    logic [VAL_W-1:0]    val;
    logic [TUBE_B_W-1:0] tube_b;
    logic                tube_sat;
  } fcw_side_t;

  typedef logic [TANH_W-1:0] tanh_rom_t [TANH_TABLE_ENTRIES+1];

  // Shift-subtract division, used only while the table is elaborated.
  function automatic longint unsigned udiv64(longint unsigned a, longint unsigned b);
    longint unsigned q;
    longint unsigned r;
    q = 0;
    r = 0;
    for (int i = 63; i >= 0; i--) begin
      r = (r << 1) | ((a >> i) & 64'd1);
      if (r >= b) begin
        r = r - b;
        q = q | (64'd1 << i);
      end
    end
    return q;
  endfunction

  // e^-y, y and result in Q.30: Taylor series of e^-(y/16), squared four times.
  function automatic longint unsigned exp_neg_q30(longint unsigned y);
    longint unsigned z;
    longint unsigned term;
    longint          sum;
    longint unsigned r;
    z    = y >> 4;
    term = 64'd1 << 30;
    sum  = 64'sd1 << 30;
    for (int k = 1; k <= 14; k++) begin
      term = udiv64((term * z) >> 30, longint'(k));
      if (k % 2 == 1) sum = sum - longint'(term);
      else            sum = sum + longint'(term);
    end
    r = (sum < 0) ? 64'd0 : longint'(sum);
    for (int k = 0; k < 4; k++) begin
      r = (r * r + (64'd1 << 29)) >> 30;
    end
    return r;
  endfunction

  function automatic logic [TANH_W-1:0] tanh_entry(int i);
    longint unsigned y;
    longint unsigned e;
    longint unsigned num;
    longint unsigned den;
    y = (longint'(16 * i) << 30) / TANH_TABLE_ENTRIES;
    e = exp_neg_q30(y);
    if (e > (64'd1 << 30)) e = 64'd1 << 30;
    num = (64'd1 << 30) - e;
    den = (64'd1 << 30) + e;
    return TANH_W'(udiv64((num << 20) + (den >> 1), den));
  endfunction

  function automatic tanh_rom_t build_tanh_rom();
    tanh_rom_t rom;
    for (int i = 0; i <= TANH_TABLE_ENTRIES; i++) begin
      rom[i] = tanh_entry(i);
    end
    return rom;
  endfunction

  localparam tanh_rom_t TANH_ROM = build_tanh_rom();

endpackage

### src/four_curve_waveshaper.sv
// Top level of the four-curve waveshaper: handshake, curve register, final sum.
// Depends on fcw_pkg, fcw_front, fcw_div and fcw_curves.
//
// One sample beat in, one shaped sample beat out, in order. The block takes a
// beat every clock while the output side keeps up. Each beat passes through
// three front stages (sign split, drive multiply, rounding), the tube curve's
// divider, which retires one quotient bit per stage over 21 stages plus a
// setup stage, and the output register. All curves run through the same
// pipeline, so latency does not depend on the curve. A stall on the output
// while the output register holds a beat freezes the whole pipeline and is
// passed back to in_stall in the same cycle. The curve register is
// written over the cfg_ port (ready is always high) and travels with each
// beat from its entry, so change it only while no beat is in flight.
// Tanh table: TANH_TABLE_ENTRIES+1 constant entries, built at elaboration.
module four_curve_waveshaper (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [fcw_pkg::SAMPLE_W-1:0] in_sample_in,
  input  logic [fcw_pkg::GAIN_W-1:0]          in_drive_gain,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [fcw_pkg::SAMPLE_W-1:0] out_sample_out,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [1:0]                          cfg_curve_type
);
  import fcw_pkg::*;

  localparam logic signed [SAMPLE_W-1:0] LIM_ONE  = SAMPLE_W'(ONE_Q20);
  localparam logic signed [SAMPLE_W-1:0] LIM_SOFT = SAMPLE_W'(TWO_THIRDS);

  curve_t                     curve_r;
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  curve_t                     out_curve_r;

  logic                       adv;
  fcw_mag_t                   mag;
  fcw_side_t                  side;
  logic                       div_valid;
  logic [DIV_Q_BITS-1:0]      quot;

  logic signed [RES_W-1:0]    tube_a;
  logic signed [RES_W-1:0]    res_nxt;
  logic signed [SAMPLE_W-1:0] sample_nxt;

  // advance whenever the output register is empty or being taken
  assign adv       = ~out_valid_r | ~out_stall;
  assign in_stall  = ~adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      curve_r <= CURVE_TAPE;
    end else if (cfg_valid) begin
      curve_r <= curve_t'(cfg_curve_type);
    end
  end

  fcw_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_valid   (in_valid),
    .sample_in  (in_sample_in),
    .drive_gain (in_drive_gain),
    .curve      (curve_r),
    .mag_o      (mag)
  );

  fcw_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .mag_i   (mag),
    .valid_o (div_valid),
    .quot_o  (quot)
  );

  fcw_curves u_curves (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .mag_i  (mag),
    .side_o (side)
  );

  // Tube: signed quotient plus the square term; others: sign the magnitude.
  assign tube_a = side.neg ? -$signed(RES_W'(quot)) : $signed(RES_W'(quot));

  always_comb begin
    if (side.curve == CURVE_TUBE) begin
      res_nxt = tube_a + $signed(RES_W'(side.tube_b));
    end else begin
      res_nxt = side.neg ? -$signed(RES_W'(side.val)) : $signed(RES_W'(side.val));
    end
  end

  // saturate to the Q4.20 range; an oversized square term always clips high
  always_comb begin
    if ((side.curve == CURVE_TUBE && side.tube_sat) ||
        res_nxt > $signed(RES_W'(OUT_MAX))) begin
      sample_nxt = SAMPLE_W'(OUT_MAX);
    end else if (res_nxt < $signed(RES_W'(OUT_MIN))) begin
      sample_nxt = SAMPLE_W'(OUT_MIN);
    end else begin
      sample_nxt = res_nxt[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= side.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_sample_r <= sample_nxt;
      out_curve_r  <= side.curve;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

  // divider and curve paths must hand over the same beat
  assert property (@(posedge clk) disable iff (!rst_n)
    div_valid == side.valid)
    else $error("divider and curve pipelines out of step");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_curve_r == CURVE_HARD) |->
      (out_sample_r <= LIM_ONE && out_sample_r >= -LIM_ONE))
    else $error("hard clip result beyond unity");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_curve_r == CURVE_SOFT) |->
      (out_sample_r <= LIM_SOFT && out_sample_r >= -LIM_SOFT))
    else $error("soft clip result beyond two thirds");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_curve_r == CURVE_TAPE) |->
      (out_sample_r <= LIM_ONE && out_sample_r >= -LIM_ONE))
    else $error("tape result beyond unity");

endmodule

### src/fcw_front.sv
// Front end of the waveshaper: sign split, drive multiply and rounding to |d|.
// Depends on fcw_pkg.
module fcw_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  logic                           in_valid,
  input  logic signed [fcw_pkg::SAMPLE_W-1:0] sample_in,
  input  logic [fcw_pkg::GAIN_W-1:0]     drive_gain,
  input  fcw_pkg::curve_t                curve,
  output fcw_pkg::fcw_mag_t              mag_o
);
  import fcw_pkg::*;

  logic                s1_valid_r;
  logic                s1_neg_r;
  curve_t              s1_curve_r;
  logic [SAMPLE_W-1:0] s1_smag_r;
  logic [GAIN_W-1:0]   s1_gain_r;
  logic                s2_valid_r;
  logic                s2_neg_r;
  curve_t              s2_curve_r;
  logic [PROD_W-1:0]   s2_prod_r;
  fcw_mag_t            s3_r;

  logic [SAMPLE_W-1:0] smag_nxt;
  logic [PROD_W-1:0]   rnd_sum;
  logic [MAG_W-1:0]    mag_nxt;

  assign smag_nxt = sample_in[SAMPLE_W-1] ? (~$unsigned(sample_in) + 1'b1)
                                          : $unsigned(sample_in);
  assign rnd_sum  = s2_prod_r + PROD_W'(ROUND_HALF);
  assign mag_nxt  = rnd_sum[MAG_W+ROUND_SHIFT-1:ROUND_SHIFT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_r.valid <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_r.valid <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_neg_r   <= sample_in[SAMPLE_W-1];
      s1_curve_r <= curve;
      s1_smag_r  <= smag_nxt;
      s1_gain_r  <= drive_gain;
      s2_neg_r   <= s1_neg_r;
      s2_curve_r <= s1_curve_r;
      s2_prod_r  <= s1_smag_r * s1_gain_r;
      // zero magnitude carries no sign
      s3_r.neg   <= s2_neg_r & (mag_nxt != '0);
      s3_r.curve <= s2_curve_r;
      s3_r.mag   <= mag_nxt;
    end
  end

  assign mag_o = s3_r;

endmodule

### src/fcw_div.sv
// Pipelined restoring divider for the tube term, one quotient bit per stage.
// Depends on fcw_pkg.
module fcw_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  fcw_pkg::fcw_mag_t             mag_i,
  output logic                          valid_o,
  output logic [fcw_pkg::DIV_Q_BITS-1:0] quot_o
);
  import fcw_pkg::*;

  logic                  v_r   [DIV_LAT];
  logic [DEN_W-1:0]      den_r [DIV_LAT];
  logic [DEN_W-1:0]      rem_r [DIV_LAT];
  logic [DIV_Q_BITS-1:0] low_r [DIV_LAT];
  logic [DIV_Q_BITS-1:0] q_r   [DIV_LAT];

  logic [DEN_W-1:0]     den_nxt;
  logic [DIV_NUM_W-1:0] num_nxt;

  // numerator carries the half-divisor so the quotient comes out rounded
  assign den_nxt = DEN_W'(ONE_Q20) + DEN_W'(mag_i.mag);
  assign num_nxt = (DIV_NUM_W'(mag_i.mag) << FRAC_W) + DIV_NUM_W'(den_nxt >> 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= mag_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      den_r[0] <= den_nxt;
      rem_r[0] <= DEN_W'(num_nxt[DIV_NUM_W-1:DIV_Q_BITS]);
      low_r[0] <= num_nxt[DIV_Q_BITS-1:0];
      q_r[0]   <= '0;
    end
  end

  for (genvar k = 1; k < DIV_LAT; k++) begin : g_step
    logic [DEN_W:0] trial;
    logic           ge;

    assign trial = {rem_r[k-1], low_r[k-1][DIV_Q_BITS-1]};
    assign ge    = trial >= {1'b0, den_r[k-1]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (adv) begin
        v_r[k] <= v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        den_r[k] <= den_r[k-1];
        rem_r[k] <= ge ? DEN_W'(trial - {1'b0, den_r[k-1]}) : DEN_W'(trial);
        low_r[k] <= low_r[k-1] << 1;
        q_r[k]   <= {q_r[k-1][DIV_Q_BITS-2:0], ge};
      end
    end
  end

  assign valid_o = v_r[DIV_LAT-1];
  assign quot_o  = q_r[DIV_LAT-1];

endmodule

### src/fcw_curves.sv
// Tape, soft clip, hard clip and the tube square term, aligned to the divider.
// Depends on fcw_pkg (tanh table, reciprocal constants).
module fcw_curves (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  fcw_pkg::fcw_mag_t  mag_i,
  output fcw_pkg::fcw_side_t side_o
);
  import fcw_pkg::*;

  // stage 1: square, table lookup, interpolation weights
  logic                    c1_valid_r, c1_neg_r, c1_big_r, c1_small_r;
  curve_t                  c1_curve_r;
  logic [SQ_W-1:0]         c1_sq_r;
  logic [FRAC_W-1:0]       c1_m20_r;
  logic [VAL_W-1:0]        c1_hard_r;
  logic [TANH_W-1:0]       c1_t0_r, c1_t1_r;
  logic [SPAN_SHIFT-1:0]   c1_frac_r;
  logic [SPAN_SHIFT:0]     c1_wt0_r;
  // stage 2
  logic                    c2_valid_r, c2_neg_r, c2_big_r, c2_small_r, c2_bsat_r;
  curve_t                  c2_curve_r;
  logic [TANH_W+SPAN_SHIFT:0] c2_p0_r, c2_p1_r;
  logic [YB_W-1:0]         c2_yb_r;
  logic [CUBE_W-1:0]       c2_cube_r;
  logic [FRAC_W-1:0]       c2_m20_r;
  logic [VAL_W-1:0]        c2_hard_r;
  // stage 3
  logic                    c3_valid_r, c3_neg_r, c3_small_r, c3_bsat_r;
  curve_t                  c3_curve_r;
  logic [VAL_W-1:0]        c3_tape_r, c3_hard_r;
  logic [YB_W+RECIP5_W-1:0] c3_bm_r;
  logic [Y3_W-1:0]         c3_y3_r;
  logic [FRAC_W-1:0]       c3_m20_r;
  // stage 4
  logic                    c4_valid_r, c4_neg_r, c4_small_r, c4_bsat_r;
  curve_t                  c4_curve_r;
  logic [VAL_W-1:0]        c4_tape_r, c4_hard_r;
  logic [TUBE_B_W-1:0]     c4_b_r;
  logic [Y3_W+RECIP3_W-1:0] c4_cm_r;
  logic [FRAC_W-1:0]       c4_m20_r;
  // stage 5 and alignment line
  fcw_side_t               c5_r;
  fcw_side_t               line_r [SIDE_DELAY];

  logic [TANH_IDX_W:0]         idx_nxt;
  logic [SPAN_SHIFT-1:0]       frac_nxt;
  logic [SQ_W:0]               sq_sum;
  logic [YB_FULL_W-1:0]        yb_full;
  logic [CUBE_W:0]             cube_sum;
  logic [TANH_W+SPAN_SHIFT+1:0] tape_sum;
  logic [FRAC_W-1:0]           cube_term;
  logic [VAL_W-1:0]            soft_nxt;
  logic [VAL_W-1:0]            val_nxt;

  assign idx_nxt  = {1'b0, mag_i.mag[SPAN_SHIFT-1 -: TANH_IDX_W]};
  assign frac_nxt = {mag_i.mag[SPAN_SHIFT-TANH_IDX_W-1:0], TANH_IDX_W'(0)};

  assign sq_sum   = {1'b0, c1_sq_r} + (SQ_W+1)'(TUBE_BIAS);
  assign yb_full  = sq_sum[SQ_W:YB_SHIFT];
  assign cube_sum = {1'b0, c2_cube_r} + ((CUBE_W+1)'(3) << (Y3_SHIFT - 1));
  assign tape_sum = (TANH_W+SPAN_SHIFT+2)'(c2_p0_r) + (TANH_W+SPAN_SHIFT+2)'(c2_p1_r)
                  + ((TANH_W+SPAN_SHIFT+2)'(1) << (SPAN_SHIFT - 1));
  assign cube_term = c4_cm_r[RECIP3_SHIFT+FRAC_W-1:RECIP3_SHIFT];
  assign soft_nxt  = c4_small_r ? VAL_W'(c4_m20_r - cube_term) : VAL_W'(TWO_THIRDS);

  always_comb begin
    case (c4_curve_r)
      CURVE_TAPE: val_nxt = c4_tape_r;
      CURVE_SOFT: val_nxt = soft_nxt;
      CURVE_HARD: val_nxt = c4_hard_r;
      default:    val_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_valid_r <= 1'b0;
      c2_valid_r <= 1'b0;
      c3_valid_r <= 1'b0;
      c4_valid_r <= 1'b0;
      c5_r.valid <= 1'b0;
    end else if (adv) begin
      c1_valid_r <= mag_i.valid;
      c2_valid_r <= c1_valid_r;
      c3_valid_r <= c2_valid_r;
      c4_valid_r <= c3_valid_r;
      c5_r.valid <= c4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c1_neg_r   <= mag_i.neg;
      c1_curve_r <= mag_i.curve;
      c1_sq_r    <= mag_i.mag * mag_i.mag;
      c1_big_r   <= mag_i.mag[MAG_W-1:SPAN_SHIFT] != '0;
      c1_small_r <= mag_i.mag[MAG_W-1:FRAC_W] == '0;
      c1_m20_r   <= mag_i.mag[FRAC_W-1:0];
      c1_hard_r  <= (mag_i.mag > MAG_W'(ONE_Q20)) ? VAL_W'(ONE_Q20)
                                                   : mag_i.mag[VAL_W-1:0];
      c1_t0_r    <= TANH_ROM[idx_nxt];
      c1_t1_r    <= TANH_ROM[idx_nxt + 1'b1];
      c1_frac_r  <= frac_nxt;
      c1_wt0_r   <= (SPAN_SHIFT+1)'(1 << SPAN_SHIFT) - {1'b0, frac_nxt};

      c2_neg_r   <= c1_neg_r;
      c2_curve_r <= c1_curve_r;
      c2_big_r   <= c1_big_r;
      c2_small_r <= c1_small_r;
      c2_m20_r   <= c1_m20_r;
      c2_hard_r  <= c1_hard_r;
      c2_p0_r    <= c1_t0_r * c1_wt0_r;
      c2_p1_r    <= (TANH_W+SPAN_SHIFT+1)'(c1_t1_r * c1_frac_r);
      c2_yb_r    <= yb_full[YB_W-1:0];
      c2_bsat_r  <= yb_full >= YB_FULL_W'(YB_LIMIT);
      c2_cube_r  <= c1_sq_r[SOFT_SQ_W-1:0] * c1_m20_r;

      c3_neg_r   <= c2_neg_r;
      c3_curve_r <= c2_curve_r;
      c3_small_r <= c2_small_r;
      c3_m20_r   <= c2_m20_r;
      c3_hard_r  <= c2_hard_r;
      c3_bsat_r  <= c2_bsat_r;
      c3_tape_r  <= c2_big_r ? VAL_W'(TANH_ROM[TANH_TABLE_ENTRIES])
                             : tape_sum[SPAN_SHIFT+VAL_W-1:SPAN_SHIFT];
      c3_bm_r    <= c2_yb_r * RECIP5;
      c3_y3_r    <= cube_sum[CUBE_W:Y3_SHIFT];

      c4_neg_r   <= c3_neg_r;
      c4_curve_r <= c3_curve_r;
      c4_small_r <= c3_small_r;
      c4_m20_r   <= c3_m20_r;
      c4_hard_r  <= c3_hard_r;
      c4_bsat_r  <= c3_bsat_r;
      c4_tape_r  <= c3_tape_r;
      c4_b_r     <= c3_bm_r[RECIP5_SHIFT+TUBE_B_W-1:RECIP5_SHIFT];
      c4_cm_r    <= c3_y3_r * RECIP3;

      c5_r.neg      <= c4_neg_r;
      c5_r.curve    <= c4_curve_r;
      c5_r.val      <= val_nxt;
      c5_r.tube_b   <= c4_b_r;
      c5_r.tube_sat <= c4_bsat_r;
    end
  end

  // hold side results until the tube quotient catches up
  for (genvar k = 0; k < SIDE_DELAY; k++) begin : g_line
    fcw_side_t line_in;
    if (k == 0) begin : g_head
      assign line_in = c5_r;
    end else begin : g_tail
      assign line_in = line_r[k-1];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        line_r[k].valid <= 1'b0;
      end else if (adv) begin
        line_r[k] <= line_in;
      end
    end
  end

  assign side_o = line_r[SIDE_DELAY-1];

endmodule
